[rtl/mbps_pkg.sv]
// Package for the masked byte pattern scan block: item types, configuration
// register map, reset values and default sizes. Depends on nothing.
`default_nettype none

package mbps_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_CARE_MASK      = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } t_cfg_idx;

    localparam logic [63:0] PATTERN_RST = 64'd0;
    localparam logic [15:0] CARE_RST    = 16'hFFFF;
    localparam logic [4:0]  LENGTH_RST  = 5'd1;

    typedef struct packed {
        logic [63:0] pattern_low_bytes;
        logic [63:0] pattern_high_bytes;
        logic [15:0] care_mask;
        logic [4:0]  pattern_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } t_result;

    // Scan status seen by the top level
    typedef struct packed {
        logic match_done;
        logic region_clear;
    } t_front_stat;

endpackage

`default_nettype wire

[rtl/mbps_front.sv]
// Front part of the scan: sliding byte window, parallel masked compare and
// result classification. Depends on mbps_pkg.
`default_nettype none

module mbps_front #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  mbps_pkg::t_item       i_item,
    input  mbps_pkg::t_cfg        i_cfg,
    output logic                  o_res_valid,
    output mbps_pkg::t_result     o_res,
    output mbps_pkg::t_front_stat o_stat
);

    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SEEN_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             win_new [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [SEEN_W-1:0]      r_seen, n_seen;
    logic                   r_done, n_done;

    logic [127:0]           sig;
    logic [4:0]             len;
    logic [SEEN_W-1:0]      seen_inc;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic                   hit;
    logic                   match;
    logic [OFFSET_BITS-1:0] start;
    logic [63:0]            start_ext;

    assign sig = {i_cfg.pattern_high_bytes, i_cfg.pattern_low_bytes};

    // Clamp length into 1..MAX_PATTERN
    always_comb begin
        if (i_cfg.pattern_length == 5'd0) begin
            len = 5'd1;
        end else if (i_cfg.pattern_length > 5'(MAX_PATTERN)) begin
            len = 5'(MAX_PATTERN);
        end else begin
            len = i_cfg.pattern_length;
        end
    end

    // Window after this byte shifts in; entry 0 is newest
    always_comb begin
        win_new[0] = i_item.data_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            win_new[i] = r_win[i-1];
        end
    end

    assign seen_inc = (r_seen < SEEN_W'(MAX_PATTERN)) ? r_seen + SEEN_W'(1) : r_seen;

    // Signature byte k lines up with window entry len-1-k
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cmp
        logic [4:0] widx;
        assign widx = len - 5'(g) - 5'd1;
        assign byte_ok[g] = (5'(g) >= len) || !i_cfg.care_mask[g] ||
                            (sig[8*g +: 8] == win_new[widx[IDX_W-1:0]]);
    end

    assign hit   = &byte_ok;
    assign match = !r_done && (5'(seen_inc) >= len) && hit;

    assign start     = r_pos - OFFSET_BITS'(len - 5'd1);
    assign start_ext = 64'(start);

    assign o_res_valid        = i_accept && (match || (i_item.last_byte && !r_done));
    assign o_res.found        = match;
    assign o_res.match_offset = match ? start_ext[31:0] : 32'd0;

    assign o_stat.match_done   = r_done;
    assign o_stat.region_clear = (r_seen == '0) && (r_pos == '0) && !r_done;

    always_comb begin
        n_pos  = r_pos;
        n_seen = r_seen;
        n_done = r_done;
        if (i_accept) begin
            if (i_item.last_byte) begin
                n_pos  = '0;
                n_seen = '0;
                n_done = 1'b0;
            end else begin
                n_pos  = r_pos + OFFSET_BITS'(1);
                n_seen = seen_inc;
                n_done = r_done || match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= '0;
            r_done <= 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= 8'd0;
            end
        end else begin
            r_pos  <= n_pos;
            r_seen <= n_seen;
            r_done <= n_done;
            if (i_accept) begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    r_win[i] <= i_item.last_byte ? 8'd0 : win_new[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/mbps_fifo.sv]
// Short result queue between the scan front and the output stage.
// Depends on mbps_pkg for the result type.
`default_nettype none

module mbps_fifo #(
    parameter int DEPTH = mbps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  mbps_pkg::t_result i_data,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_empty,
    output mbps_pkg::t_result o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbps_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/mbps_back.sv]
// Output stage: holds one result beat on the ports and refills from the queue.
// Depends on mbps_pkg for the result type.
`default_nettype none

module mbps_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_head_valid,
    input  mbps_pkg::t_result i_head,
    output logic              o_take,
    input  wire               i_pop,
    output logic              o_empty,
    output mbps_pkg::t_result o_result
);

    logic              r_valid, n_valid;
    mbps_pkg::t_result r_result;

    // Refill when the stage is free or its beat leaves this cycle
    assign o_take = i_head_valid && (!r_valid || i_pop);

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (i_pop && r_valid) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_take) begin
            r_result <= i_head;
        end
    end

    assign o_empty  = !r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/masked_byte_pattern_scan_core.sv]
// Result path: a result beat reaches the output ports through the queue write and
//   then the output register load; it waits in the queue while that stage is busy.
// Throughput: one byte per cycle; the window compare runs on all positions at once.
//   full rises only when the QUEUE_DEPTH-entry result queue is full.
// Reset: synchronous, active low; restores register reset values, clears the scan
//   state, the result queue and the output stage. No clearing pass is needed.
`default_nettype none

module masked_byte_pattern_scan_core #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = mbps_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input side
    input  wire                              push,
    output logic                             full,
    input  mbps_pkg::t_item                  i_item,
    // result side
    output logic                             empty,
    input  wire                              pop,
    output mbps_pkg::t_result                o_result,
    // configuration writes
    input  wire                              i_cfg_we,
    input  wire [mbps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [mbps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers
    mbps_pkg::t_cfg r_cfg;

    // Front to queue
    logic                  accept;
    logic                  res_valid;
    mbps_pkg::t_result     res;
    mbps_pkg::t_front_stat stat;

    // Queue to back
    logic                  q_full;
    logic                  q_empty;
    mbps_pkg::t_result     q_head;
    logic                  q_take;

    // Write a register; index decode covers the full map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low_bytes  <= mbps_pkg::PATTERN_RST;
            r_cfg.pattern_high_bytes <= mbps_pkg::PATTERN_RST;
            r_cfg.care_mask          <= mbps_pkg::CARE_RST;
            r_cfg.pattern_length     <= mbps_pkg::LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (mbps_pkg::t_cfg_idx'(i_cfg_idx))
                mbps_pkg::CFG_PATTERN_LOW: begin
                    r_cfg.pattern_low_bytes <= i_cfg_data;
                end
                mbps_pkg::CFG_PATTERN_HIGH: begin
                    r_cfg.pattern_high_bytes <= i_cfg_data;
                end
                mbps_pkg::CFG_CARE_MASK: begin
                    r_cfg.care_mask <= i_cfg_data[15:0];
                end
                mbps_pkg::CFG_PATTERN_LENGTH: begin
                    r_cfg.pattern_length <= i_cfg_data[4:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Take a byte whenever the queue has room for its possible result
    assign full   = q_full;
    assign accept = push && !q_full;

    // Front: shift window, compare, classify
    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_stat      (stat)
    );

    // Queue: decouple scanning from result delivery
    mbps_fifo #(
        .DEPTH   (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (q_take),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: hold the oldest result beat on the ports
    mbps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_take       (q_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

`ifndef SYNTH
    // The final byte of a region leaves the scan state cleared
    a_region_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.last_byte |=> stat.region_clear)
        else $error("scan state not cleared after last byte");

    // A miss beat never carries an offset
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res.found |-> res.match_offset == 32'd0)
        else $error("miss result carries nonzero offset");

    // A hit inside a region silences the rest of it
    a_hit_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.found && !i_item.last_byte |=> stat.match_done)
        else $error("match not recorded after hit");

    // Results enter the queue only for accepted bytes
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> accept)
        else $error("result produced without accepted byte");
`endif

endmodule

`default_nettype wire
